// File: src/pmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_pkg
// Shared widths, register codes and slot types of the pattern match ranker.
// ----------------------------------------------------------------------------
package pmr_pkg;

    localparam int unsigned ID_W           = 16;
    localparam int unsigned DIST_IN_W      = 16;
    localparam int unsigned ERR_W          = 34;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned RANK_DEPTH_DEF = 8;
    localparam int unsigned DIST_WIDTH_DEF = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_FIRST  = 2'd0,
        CFG_QUERY_SECOND = 2'd1,
        CFG_QUERY_THIRD  = 2'd2
    } t_cfg_index;

    // One ranked candidate held in a cell
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic [ERR_W-1:0] err;
    } t_rank_slot;

    // Item leaving the error pipeline
    typedef struct packed {
        logic            valid;
        logic            present;
        logic            last;
        logic [ID_W-1:0] id;
        logic [ERR_W-1:0] err;
    } t_err_item;

endpackage

// File: src/pmr_err_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_err_pipe
// Three-stage squared error pipeline: differences, squares, sum.
// ----------------------------------------------------------------------------
module pmr_err_pipe #(
    parameter int unsigned DIST_WIDTH = pmr_pkg::DIST_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_present,
    input  logic                             i_last,
    input  logic [pmr_pkg::ID_W-1:0]         i_star_id,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_dist_first,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_dist_second,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_dist_third,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_query_first,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_query_second,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_query_third,
    output pmr_pkg::t_err_item               o_item,
    output logic                             o_last_in_flight
);

    // Distances are taken in their low DIST_WIDTH bits, at most DIST_IN_W bits
    localparam int unsigned DW = (DIST_WIDTH < pmr_pkg::DIST_IN_W) ?
                                 DIST_WIDTH : pmr_pkg::DIST_IN_W;
    localparam int unsigned SW = 2 * DW;
    localparam int unsigned PAD_W = pmr_pkg::ERR_W - SW;

    function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a,
                                               input logic [DW-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Stage control
    logic r_s1_valid, r_s2_valid, r_s3_valid;
    logic r_s1_present, r_s2_present, r_s3_present;
    logic r_s1_last, r_s2_last, r_s3_last;

    // Stage payload
    logic [pmr_pkg::ID_W-1:0]  r_s1_id, r_s2_id, r_s3_id;
    logic [DW-1:0]             r_s1_d1, r_s1_d2, r_s1_d3;
    logic [SW-1:0]             r_s2_q1, r_s2_q2, r_s2_q3;
    logic [pmr_pkg::ERR_W-1:0] r_s3_err;

    // Advance control flags every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Stage 1: absolute differences
    always_ff @(posedge i_clk) begin
        r_s1_present <= i_present;
        r_s1_last    <= i_last;
        r_s1_id      <= i_star_id;
        r_s1_d1      <= abs_diff(i_dist_first[DW-1:0],  i_query_first[DW-1:0]);
        r_s1_d2      <= abs_diff(i_dist_second[DW-1:0], i_query_second[DW-1:0]);
        r_s1_d3      <= abs_diff(i_dist_third[DW-1:0],  i_query_third[DW-1:0]);
    end

    // Stage 2: squares
    always_ff @(posedge i_clk) begin
        r_s2_present <= r_s1_present;
        r_s2_last    <= r_s1_last;
        r_s2_id      <= r_s1_id;
        r_s2_q1      <= SW'(r_s1_d1) * SW'(r_s1_d1);
        r_s2_q2      <= SW'(r_s1_d2) * SW'(r_s1_d2);
        r_s2_q3      <= SW'(r_s1_d3) * SW'(r_s1_d3);
    end

    // Stage 3: sum of squares
    always_ff @(posedge i_clk) begin
        r_s3_present <= r_s2_present;
        r_s3_last    <= r_s2_last;
        r_s3_id      <= r_s2_id;
        r_s3_err     <= {{PAD_W{1'b0}}, r_s2_q1} + {{PAD_W{1'b0}}, r_s2_q2}
                      + {{PAD_W{1'b0}}, r_s2_q3};
    end

    assign o_item.valid   = r_s3_valid;
    assign o_item.present = r_s3_present;
    assign o_item.last    = r_s3_last;
    assign o_item.id      = r_s3_id;
    assign o_item.err     = r_s3_err;

    assign o_last_in_flight = (r_s1_valid && r_s1_last) || (r_s2_valid && r_s2_last)
                            || (r_s3_valid && r_s3_last);

endmodule

// File: src/pmr_rank_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_rank_cell
// One slot of the sorted insertion chain: keep, take the new entry, or shift.
// ----------------------------------------------------------------------------
module pmr_rank_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_insert,
    input  logic                      i_flush,
    input  logic [pmr_pkg::ID_W-1:0]  i_new_id,
    input  logic [pmr_pkg::ERR_W-1:0] i_new_err,
    input  pmr_pkg::t_rank_slot       i_prev,
    input  logic                      i_prev_keep,
    output pmr_pkg::t_rank_slot       o_slot,
    output logic                      o_keep,
    output pmr_pkg::t_rank_slot       o_next
);

    logic                      r_valid;
    logic [pmr_pkg::ID_W-1:0]  r_id;
    logic [pmr_pkg::ERR_W-1:0] r_err;

    // Equal errors stay ahead of the new entry
    assign o_keep = r_valid && (r_err <= i_new_err);

    // Pick the slot content after this cycle's insertion
    always_comb begin
        o_next.valid = r_valid;
        o_next.id    = r_id;
        o_next.err   = r_err;
        if (i_insert && !o_keep) begin
            if (i_prev_keep) begin
                o_next.valid = 1'b1;
                o_next.id    = i_new_id;
                o_next.err   = i_new_err;
            end else begin
                o_next = i_prev;
            end
        end
    end

    // Drop the contents on flush; the output chain has taken a copy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= o_next.valid && !i_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= o_next.id;
        r_err <= o_next.err;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.id    = r_id;
    assign o_slot.err   = r_err;

endmodule

// File: src/pmr_out_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_out_cell
// One slot of the output shift chain that plays a finished ranking out.
// ----------------------------------------------------------------------------
module pmr_out_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  pmr_pkg::t_rank_slot i_load_slot,
    input  logic                i_shift,
    input  pmr_pkg::t_rank_slot i_next_slot,
    output pmr_pkg::t_rank_slot o_slot
);

    logic                      r_valid;
    logic [pmr_pkg::ID_W-1:0]  r_id;
    logic [pmr_pkg::ERR_W-1:0] r_err;
    pmr_pkg::t_rank_slot       n_slot;

    // Load a whole ranking, or move one slot toward the head
    always_comb begin
        n_slot.valid = r_valid;
        n_slot.id    = r_id;
        n_slot.err   = r_err;
        if (i_load) begin
            n_slot = i_load_slot;
        end else if (i_shift) begin
            n_slot = i_next_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_slot.id;
        r_err <= n_slot.err;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.id    = r_id;
    assign o_slot.err   = r_err;

endmodule

// File: src/pattern_match_ranker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_match_ranker_unit
// Top-K ranking of database entries by squared distance error to a query.
// ----------------------------------------------------------------------------
// Usage:
//   Write the three query distances through the configuration port while the
//   block is idle. Stream database entries on the entry channel (valid/ready);
//   one item is taken per cycle while ready is high. Each entry goes through
//   a three-stage error pipeline and then into a chain of RANK_DEPTH cells that
//   keeps the best entries sorted by ascending error, ties behind earlier entries.
//   An item with entry_last closes the pass: once it leaves the third pipeline
//   stage, the ranking moves into the output chain and the ranking cells empty.
//   Results then leave on the ranked channel best first, one per cycle while
//   the receiver is ready; a pass without entries gives one result flagged
//   empty. A stalled receiver holds the head result, and entries of the next
//   pass keep flowing into the ranking cells. A further last item waits
//   (ready low) until the previous output has been taken up to its final
//   result and no earlier last item is still in the pipeline.
//   Reset clears the query registers, the ranking and the output chain.
// ----------------------------------------------------------------------------
module pattern_match_ranker_unit #(
    parameter int unsigned RANK_DEPTH = pmr_pkg::RANK_DEPTH_DEF,
    parameter int unsigned DIST_WIDTH = pmr_pkg::DIST_WIDTH_DEF,
    localparam int unsigned POS_W = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_wr_en,
    input  logic [pmr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pmr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Entry channel
    input  logic                             i_entry_valid,
    output logic                             o_entry_ready,
    input  logic                             i_entry_present,
    input  logic [pmr_pkg::ID_W-1:0]         i_entry_star_id,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_entry_dist_first,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_entry_dist_second,
    input  logic [pmr_pkg::DIST_IN_W-1:0]    i_entry_dist_third,
    input  logic                             i_entry_last,
    // Ranked channel
    output logic                             o_ranked_valid,
    input  logic                             i_ranked_ready,
    output logic [pmr_pkg::ID_W-1:0]         o_ranked_star_id,
    output logic [pmr_pkg::ERR_W-1:0]        o_ranked_error,
    output logic [POS_W-1:0]                 o_ranked_position,
    output logic                             o_ranked_empty,
    output logic                             o_ranked_last
);

    logic [pmr_pkg::DIST_IN_W-1:0] r_query_first, r_query_second, r_query_third;
    logic                          r_out_empty;
    logic [POS_W-1:0]              r_out_pos;

    logic                w_accept;
    logic                w_last_in_flight;
    logic                w_insert;
    logic                w_flush;
    logic                w_pop;
    pmr_pkg::t_err_item  w_item;
    pmr_pkg::t_rank_slot w_empty_slot;

    pmr_pkg::t_rank_slot w_rank_slot [RANK_DEPTH];
    pmr_pkg::t_rank_slot w_rank_next [RANK_DEPTH];
    logic                w_rank_keep [RANK_DEPTH];
    pmr_pkg::t_rank_slot w_out_slot  [RANK_DEPTH+1];

    // Write query registers; other indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_first  <= '0;
            r_query_second <= '0;
            r_query_third  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pmr_pkg::CFG_QUERY_FIRST:  r_query_first  <= i_cfg_data;
                pmr_pkg::CFG_QUERY_SECOND: r_query_second <= i_cfg_data;
                pmr_pkg::CFG_QUERY_THIRD:  r_query_third  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold back a last item until the output chain is free for it
    assign o_entry_ready = !i_entry_last ||
                           (!w_last_in_flight &&
                            (!w_out_slot[0].valid || (i_ranked_ready && o_ranked_last)));
    assign w_accept = i_entry_valid && o_entry_ready;

    pmr_err_pipe #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_err_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_present        (i_entry_present),
        .i_last           (i_entry_last),
        .i_star_id        (i_entry_star_id),
        .i_dist_first     (i_entry_dist_first),
        .i_dist_second    (i_entry_dist_second),
        .i_dist_third     (i_entry_dist_third),
        .i_query_first    (r_query_first),
        .i_query_second   (r_query_second),
        .i_query_third    (r_query_third),
        .o_item           (w_item),
        .o_last_in_flight (w_last_in_flight)
    );

    assign w_insert = w_item.valid && w_item.present;
    assign w_flush  = w_item.valid && w_item.last;
    assign w_pop    = o_ranked_valid && i_ranked_ready;

    assign w_empty_slot.valid = 1'b1;
    assign w_empty_slot.id    = '0;
    assign w_empty_slot.err   = '0;

    // Ranking chain and output chain
    assign w_out_slot[RANK_DEPTH] = '0;

    for (genvar g = 0; g < RANK_DEPTH; g++) begin : g_cell
        pmr_pkg::t_rank_slot w_prev;
        logic                w_prev_keep;
        pmr_pkg::t_rank_slot w_load;

        if (g == 0) begin : g_head
            assign w_prev      = '0;
            assign w_prev_keep = 1'b1;
            assign w_load      = w_rank_next[0].valid ? w_rank_next[0] : w_empty_slot;
        end else begin : g_body
            assign w_prev      = w_rank_slot[g-1];
            assign w_prev_keep = w_rank_keep[g-1];
            assign w_load      = w_rank_next[g];
        end

        pmr_rank_cell u_rank_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_insert    (w_insert),
            .i_flush     (w_flush),
            .i_new_id    (w_item.id),
            .i_new_err   (w_item.err),
            .i_prev      (w_prev),
            .i_prev_keep (w_prev_keep),
            .o_slot      (w_rank_slot[g]),
            .o_keep      (w_rank_keep[g]),
            .o_next      (w_rank_next[g])
        );

        pmr_out_cell u_out_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_flush),
            .i_load_slot (w_load),
            .i_shift     (w_pop),
            .i_next_slot (w_out_slot[g+1]),
            .o_slot      (w_out_slot[g])
        );
    end

    // Track position and the empty-pass flag of the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_pos   <= '0;
            r_out_empty <= 1'b0;
        end else if (w_flush) begin
            r_out_pos   <= '0;
            r_out_empty <= !w_rank_next[0].valid;
        end else if (w_pop) begin
            r_out_pos   <= r_out_pos + 1'b1;
        end
    end

    assign o_ranked_valid    = w_out_slot[0].valid;
    assign o_ranked_star_id  = w_out_slot[0].id;
    assign o_ranked_error    = w_out_slot[0].err;
    assign o_ranked_position = r_out_pos;
    assign o_ranked_empty    = r_out_empty;
    assign o_ranked_last     = !w_out_slot[1].valid;

    // A ranking is only moved into an empty output chain
    a_load_into_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flush |-> !w_out_slot[0].valid)
        else $error("ranking loaded while output chain busy");

    // An empty pass gives a single result at position zero
    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ranked_valid && o_ranked_empty) |-> (o_ranked_last && o_ranked_position == '0))
        else $error("empty result not single");

    // A taken non-final result is followed by the next position
    a_next_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ranked_valid && i_ranked_ready && !o_ranked_last) |=>
        (o_ranked_valid && o_ranked_position == POS_W'($past(o_ranked_position) + 1'b1)))
        else $error("ranked output broke off or skipped a position");

endmodule
